[sv/olpid_pkg.sv]
// shared types, widths and codes for the ordered list block
// no dependencies; imported by the controller, datapath and top level
package olpid_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int OP_W     = 3;
   localparam int VAL_W    = 32;
   localparam int POS_W    = 11;
   localparam int ST_W     = 2;
   localparam int ECNT_W   = 11;
   localparam int REQ_W    = ((OP_W + VAL_W + POS_W + 7) / 8) * 8;
   localparam int RSP_W    = ((VAL_W + ST_W + ECNT_W + 7) / 8) * 8;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND     = 3'd0,
      OP_INS_HEAD   = 3'd1,
      OP_REM_TAIL   = 3'd2,
      OP_REM_HEAD   = 3'd3,
      OP_INS_POS    = 3'd4,
      OP_REM_POS    = 3'd5
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      KIND_NOP,
      KIND_INS,
      KIND_REM
   } kind_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_SHIFT_UP,
      S_READ,
      S_TAKE,
      S_SHIFT_DN,
      S_DRAIN,
      S_PUT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic shift_up;
      logic shift_dn;
      logic read_got;
      logic take_got;
      logic put;
      logic dec;
      logic emit;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     more_up;
      logic     more_dn;
   } stat_type;

endpackage

[sv/olpid_ctrl.sv]
// controller state machine: sequences decode, entry shifts, write-back and result
// depends on olpid_pkg
module olpid_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  olpid_pkg::stat_type stat,
   output olpid_pkg::cmd_type  cmd
);
   import olpid_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            unique case (stat.kind)
               KIND_INS: state_in = S_SHIFT_UP;
               KIND_REM: state_in = S_READ;
               default:  state_in = S_DONE;
            endcase
         end
         S_SHIFT_UP: begin
            if (stat.more_up) begin
               cmd.shift_up = 1'b1;
            end else begin
               state_in = S_DRAIN;
            end
         end
         S_READ: begin
            cmd.read_got = 1'b1;
            state_in     = S_TAKE;
         end
         S_TAKE: begin
            cmd.take_got = 1'b1;
            state_in     = S_SHIFT_DN;
         end
         S_SHIFT_DN: begin
            if (stat.more_dn) begin
               cmd.shift_dn = 1'b1;
            end else begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (stat.kind == KIND_INS) begin
               state_in = S_PUT;
            end else begin
               cmd.dec  = 1'b1;
               state_in = S_DONE;
            end
         end
         S_PUT: begin
            cmd.put  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule

[sv/olpid_dp.sv]
// datapath: list memory, entry count, shift cursor and result register
// depends on olpid_pkg
module olpid_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [olpid_pkg::REQ_W-1:0]   req_tdata,
   output logic [olpid_pkg::RSP_W-1:0]   rsp_tdata,
   input  olpid_pkg::cmd_type            cmd,
   output olpid_pkg::stat_type           stat
);
   import olpid_pkg::*;

   logic [VAL_W-1:0] mem [CAPACITY];

   op_type           op;
   logic [VAL_W-1:0] req_value;
   logic [POS_W-1:0] req_pos, pos_c, pm1, cnt_w, last_w, idx_w;
   kind_type         kind_w;
   status_type       st_w;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] cursor_ff, cursor_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   kind_type         kind_ff, kind_in;
   status_type       st_ff, st_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic [VAL_W-1:0] got_ff, got_in;
   logic [VAL_W-1:0] rd_data_ff;
   logic             pend_ff, pend_in;
   logic [CNT_W-1:0] pend_addr_ff, pend_addr_in;
   logic [RSP_W-1:0] out_ff, out_in;
   logic [CNT_W-1:0] rd_ptr;

   assign op        = op_type'(req_tdata[OP_W-1:0]);
   assign req_value = req_tdata[OP_W +: VAL_W];
   assign req_pos   = req_tdata[OP_W + VAL_W +: POS_W];

   always_comb begin
      pos_c  = (req_pos == '0) ? POS_W'(1) : req_pos;
      pm1    = pos_c - POS_W'(1);
      cnt_w  = POS_W'(cnt_ff);
      last_w = cnt_w - POS_W'(1);
      kind_w = KIND_NOP;
      st_w   = ST_OK;
      idx_w  = '0;
      unique case (op) inside
         OP_APPEND, OP_INS_HEAD, OP_INS_POS: begin
            if (cnt_ff == CNT_W'(CAPACITY)) begin
               st_w = ST_FULL;
            end else begin
               kind_w = KIND_INS;
               if (op == OP_APPEND) begin
                  idx_w = cnt_w;
               end else if (op == OP_INS_HEAD) begin
                  idx_w = '0;
               end else begin
                  idx_w = (pm1 > cnt_w) ? cnt_w : pm1;
               end
            end
         end
         OP_REM_TAIL, OP_REM_HEAD, OP_REM_POS: begin
            if (cnt_ff == '0) begin
               st_w = ST_EMPTY;
            end else begin
               kind_w = KIND_REM;
               if (op == OP_REM_TAIL) begin
                  idx_w = last_w;
               end else if (op == OP_REM_HEAD) begin
                  idx_w = '0;
               end else begin
                  idx_w = (pm1 > last_w) ? last_w : pm1;
               end
            end
         end
         default: kind_w = KIND_NOP;
      endcase
   end

   assign rd_ptr = cmd.shift_up ? (cursor_ff - CNT_W'(1)) : cursor_ff;

   always_comb begin
      cnt_in       = cnt_ff;
      cursor_in    = cursor_ff;
      idx_in       = idx_ff;
      kind_in      = kind_ff;
      st_in        = st_ff;
      value_in     = value_ff;
      got_in       = got_ff;
      out_in       = out_ff;
      pend_in      = cmd.shift_up || cmd.shift_dn;
      pend_addr_in = cmd.shift_up ? cursor_ff : (cursor_ff - CNT_W'(1));
      if (cmd.load) begin
         kind_in   = kind_w;
         st_in     = st_w;
         value_in  = req_value;
         idx_in    = CNT_W'(idx_w);
         got_in    = '0;
         cursor_in = (kind_w == KIND_INS) ? cnt_ff : CNT_W'(idx_w);
      end
      if (cmd.shift_up) begin
         cursor_in = cursor_ff - CNT_W'(1);
      end else if (cmd.shift_dn || cmd.read_got) begin
         cursor_in = cursor_ff + CNT_W'(1);
      end
      if (cmd.take_got) begin
         got_in = rd_data_ff;
      end
      if (cmd.put) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (cmd.dec) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
      if (cmd.emit) begin
         out_in = RSP_W'({ECNT_W'(cnt_ff), st_ff, got_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         pend_ff <= pend_in;
      end
      cursor_ff    <= cursor_in;
      idx_ff       <= idx_in;
      kind_ff      <= kind_in;
      st_ff        <= st_in;
      value_ff     <= value_in;
      got_ff       <= got_in;
      pend_addr_ff <= pend_addr_in;
      out_ff       <= out_in;
   end

   // one read port, one write port; a shifted entry is written in the cycle after its read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_ptr[IDX_W-1:0]];
      if (pend_ff) begin
         mem[pend_addr_ff[IDX_W-1:0]] <= rd_data_ff;
      end else if (cmd.put) begin
         mem[idx_ff[IDX_W-1:0]] <= value_ff;
      end
   end

   assign stat.kind    = kind_ff;
   assign stat.more_up = cursor_ff > idx_ff;
   assign stat.more_dn = cursor_ff < cnt_ff;
   assign rsp_tdata    = out_ff;

endmodule

[sv/ordered_list_positional_insert_delete.sv]
// ordered list with positional insert and remove, top level
// depends on olpid_pkg, olpid_ctrl and olpid_dp
//
// usage
//   req channel: one transfer per list operation (append, insert at head,
//   remove tail, remove head, insert at position, remove at position).
//   rsp channel: exactly one transfer per operation, in order, carrying the
//   removed value (zero unless a remove succeeded), the status (ok, empty,
//   full) and the entry count after the operation.
//   sequence: an insert decides, moves each stored entry at or above its slot
//   up one place, drains the pending write and puts the new value; a remove
//   decides, reads and takes the entry, moves the entries above it down one
//   place, drains and lowers the count; dropped, empty and unused-opcode
//   cases skip the list and go straight to the result.
//   operations: one at a time; the entry shift through the list memory moves
//   one entry per cycle.
//   req_tready is high only while the controller is idle; a finished result
//   sits in the output register so the next request may be taken while rsp
//   is stalled. a second result waits until that register is taken.
//   reset: synchronous, clears the entry count and the handshake state; the
//   list memory itself is not cleared as only entries below the count are read.
module ordered_list_positional_insert_delete (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // opcode [2:0], value [34:3], position [45:35], zero [47:46]
   input  logic [olpid_pkg::REQ_W-1:0]   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // removed_value [31:0], status [33:32], entry_count [44:34], zero [47:45]
   output logic [olpid_pkg::RSP_W-1:0]   rsp_tdata
);
   import olpid_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   olpid_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   olpid_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule
